FILE: src/msr_pkg.sv
// Package for the monochrome span raster engine: screen constants, item types, codes.
`default_nettype none
package msr_pkg;

    localparam int SCREEN_W  = 512;
    localparam int SCREEN_H  = 512;
    localparam int ROW_BYTES = (SCREEN_W + 7) / 8;
    localparam int COL_W     = $clog2(ROW_BYTES + 1);
    localparam int CLIP_W    = 11;

    localparam logic [7:0] FULL_MASK = 8'hff;
    localparam logic [2:0] LAST_BIT  = 3'd7;

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_INVERT = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [9:0] start_x;
        logic [9:0] row_y;
        logic [9:0] span_width;
    } in_item_t;

    typedef struct packed {
        logic [31:0] byte_address;
        logic [7:0]  bit_mask;
        logic [1:0]  raster_op;
        logic        last_write;
    } out_item_t;

    // Span parameters worked out once per item.
    typedef struct packed {
        logic             ok;
        logic [1:0]       op;
        logic [COL_W-1:0] first_col;
        logic [COL_W-1:0] last_col;
        logic [7:0]       first_mask;
        logic [7:0]       last_mask;
        logic [31:0]      row_addr;
    } span_job_t;

endpackage
`default_nettype wire

FILE: src/msr_setup.sv
// Span setup: validity check, right-edge clip, edge masks and row base address.
`default_nettype none
module msr_setup
    import msr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      load,
    input  wire in_item_t  s_item,
    input  wire logic [31:0] frame_base,
    output span_job_t      job
);

    span_job_t          job_reg;
    span_job_t          job_next;
    logic [CLIP_W-1:0]  x_end;
    logic [CLIP_W-1:0]  x2;
    logic               x_on;
    logic               y_on;
    logic [2:0]         lm_shift;

    always_comb begin
        x_on  = {1'b0, s_item.start_x} < CLIP_W'(SCREEN_W);
        y_on  = {1'b0, s_item.row_y} < CLIP_W'(SCREEN_H);
        x_end = CLIP_W'(s_item.start_x) + CLIP_W'(s_item.span_width) - CLIP_W'(1);
        x2    = (x_end >= CLIP_W'(SCREEN_W)) ? CLIP_W'(SCREEN_W - 1) : x_end;
        lm_shift = LAST_BIT - x2[2:0];

        job_next.ok = (s_item.operation != OP_NONE) && (s_item.span_width != 10'd0)
                      && x_on && y_on;
        job_next.op         = s_item.operation;
        job_next.first_col  = COL_W'(s_item.start_x >> 3);
        job_next.last_col   = COL_W'(x2 >> 3);
        job_next.first_mask = FULL_MASK >> s_item.start_x[2:0];
        job_next.last_mask  = FULL_MASK << lm_shift;
        job_next.row_addr   = frame_base
                              + 32'(32'(s_item.row_y) * 32'(ROW_BYTES));
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= job_next;
        end
    end

    assign job = job_reg;

endmodule
`default_nettype wire

FILE: src/msr_emit.sv
// Byte command sequencer: walks the byte columns with one shared address adder.
`default_nettype none
module msr_emit
    import msr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      start,
    input  wire span_job_t job,
    input  wire logic      m_ready,
    output logic           m_valid,
    output out_item_t      m_item,
    output logic           busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [31:0]      addr_reg, addr_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;

    logic [31:0]      add_a;
    logic [COL_W-1:0] add_b;
    logic [31:0]      add_sum;
    logic             out_free;
    logic             at_last;
    logic [7:0]       mask;

    // shared adder: row base + first column on load, +1 per byte afterwards
    always_comb begin
        add_a   = (state_reg == ST_IDLE) ? job.row_addr : addr_reg;
        add_b   = (state_reg == ST_IDLE) ? job.first_col : COL_W'(1);
        add_sum = add_a + 32'(add_b);
    end

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        at_last  = (col_reg == job.last_col);
        mask     = FULL_MASK;
        if (col_reg == job.first_col) begin
            mask = mask & job.first_mask;
        end
        if (at_last) begin
            mask = mask & job.last_mask;
        end

        state_next   = state_reg;
        col_next     = col_reg;
        addr_next    = addr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start && job.ok) begin
                    col_next   = job.first_col;
                    addr_next  = add_sum;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_item_next.byte_address = addr_reg;
                    m_item_next.bit_mask     = mask;
                    m_item_next.raster_op    = job.op;
                    m_item_next.last_write   = at_last;
                    if (at_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        col_next  = col_reg + COL_W'(1);
                        addr_next = add_sum;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg    <= col_next;
        addr_reg   <= addr_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign busy    = (state_reg == ST_RUN);

endmodule
`default_nettype wire

FILE: src/mono_span_raster_op.sv
// Top level of the monochrome span raster engine.
// A span request (set, clear or invert; start column, row, width) becomes one masked
// byte command per touched frame byte, left to right, for a 1-bit-per-pixel MSB-first
// frame of 512x512 pixels (64 bytes per row). Spans starting off screen, of zero width
// or with operation 3 give no commands; the right end is clipped to the screen edge.
// Timing: a request is set up in the cycle it is taken, loaded into the column
// sequencer in the next, and then one command per cycle leaves while m_ready is high.
// A new request is not taken while a span is in the column sequencer, which walks
// the bytes with its single address adder. s_ready returns once the last command
// of a span sits in the output register. frame_base is to be written via cfg_wr_en/
// cfg_wr_data only while the block is idle; the block itself does not enforce this.
`default_nettype none
module mono_span_raster_op
    import msr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_item
);

    logic [31:0] frame_base_reg;
    logic        pending_reg;
    logic        accept;
    logic        busy;
    span_job_t   job;

    assign accept  = s_valid && s_ready;
    assign s_ready = !pending_reg && !busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg <= 32'd0;
            pending_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                frame_base_reg <= cfg_wr_data;
            end
            pending_reg <= accept;
        end
    end

    msr_setup u_setup (
        .aclk       (aclk),
        .load       (accept),
        .s_item     (s_item),
        .frame_base (frame_base_reg),
        .job        (job)
    );

    msr_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pending_reg),
        .job     (job),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item),
        .busy    (busy)
    );

endmodule
`default_nettype wire

FILE: src/msr_checker.sv
// Port-level checker for the span raster engine, bound to the top level.
`default_nettype none
module msr_checker
    import msr_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire out_item_t   m_item
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled item changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accepting an item");

    a_busy_mid_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.last_write |-> !s_ready)
        else $error("ready while a span is unfinished");

    a_sane_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.bit_mask != 8'd0 && m_item.raster_op != OP_NONE)
        else $error("empty mask or bad op in a command");

endmodule

bind mono_span_raster_op msr_checker u_msr_checker (.*);
`default_nettype wire

FILE: verif/testbench.sv
// Testbench for mono_span_raster_op: random and directed span requests checked per byte command.
`timescale 1ns / 100ps
module testbench
    import msr_pkg::*;
();

    // Expected byte commands for accepted span requests, in emission order.
    class span_cmd_tracker;
        logic [31:0] frame_base;
        out_item_t   expected_cmds[$];
        int          errors;

        function new();
            frame_base = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function void note_request(in_item_t req);
            int unsigned x_end;
            int unsigned first_col;
            int unsigned last_col;
            int unsigned col;
            logic [7:0]  mask;
            logic [31:0] row_addr;
            out_item_t   cmd;
            if (req.operation == OP_NONE || req.span_width == 0) return;
            if (req.start_x >= SCREEN_W || req.row_y >= SCREEN_H) return;
            x_end = req.start_x + req.span_width - 1;
            if (x_end >= SCREEN_W) x_end = SCREEN_W - 1;
            first_col = 32'(req.start_x >> 3);
            last_col  = x_end >> 3;
            row_addr  = frame_base + req.row_y * ROW_BYTES;
            for (col = first_col; col <= last_col; col++) begin
                mask = FULL_MASK;
                if (col == first_col) mask &= FULL_MASK >> req.start_x[2:0];
                if (col == last_col) mask &= FULL_MASK << (7 - (x_end % 8));
                cmd.byte_address = row_addr + col;
                cmd.bit_mask     = mask;
                cmd.raster_op    = req.operation;
                cmd.last_write   = (col == last_col);
                expected_cmds.push_back(cmd);
            end
        endfunction

        function void check_command(out_item_t got);
            out_item_t want;
            if (expected_cmds.size() == 0) begin
                $display("%0t: unexpected byte command, got %h", $time, got);
                errors++;
                return;
            end
            want = expected_cmds.pop_front();
            if (got.byte_address !== want.byte_address) begin
                $display("%0t: byte_address expected %h got %h", $time,
                         want.byte_address, got.byte_address);
                errors++;
            end
            if (got.bit_mask !== want.bit_mask) begin
                $display("%0t: bit_mask expected %h got %h", $time,
                         want.bit_mask, got.bit_mask);
                errors++;
            end
            if (got.raster_op !== want.raster_op) begin
                $display("%0t: raster_op expected %0d got %0d", $time,
                         want.raster_op, got.raster_op);
                errors++;
            end
            if (got.last_write !== want.last_write) begin
                $display("%0t: last_write expected %b got %b", $time,
                         want.last_write, got.last_write);
                errors++;
            end
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_item_t    s_item      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_item_t   m_item;

    span_cmd_tracker tracker = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_tickets = 0;
    int stall_served  = 0;
    int hold_left     = 0;

    mono_span_raster_op u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random back-pressure, plus a long hold-off on request to fill the block.
    always @(posedge aclk) begin
        if (m_valid && m_ready) tracker.check_command(m_item);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_served != stall_tickets) begin
            stall_served <= stall_tickets;
            hold_left    <= 400;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // All tasks are entered right after a rising edge.
    task automatic send_span(in_item_t req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(req);
    endtask

    // Requests that give no commands may still be in flight, so wait out a full span.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    task automatic set_frame_base(logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.frame_base = value;
    endtask

    function automatic in_item_t make_span_request();
        in_item_t req;
        int       pick;
        req.operation = 2'($urandom_range(2));
        req.start_x   = 10'($urandom_range(SCREEN_W - 1));
        req.row_y     = 10'($urandom_range(SCREEN_H - 1));
        pick = $urandom_range(99);
        if (pick < 60) req.span_width = 10'($urandom_range(24, 1));
        else if (pick < 85) req.span_width = 10'($urandom_range(200, 1));
        else req.span_width = 10'($urandom_range(1023));
        // a few malformed requests: bad op, off screen, zero width
        pick = $urandom_range(99);
        if (pick < 3) req.operation = OP_NONE;
        else if (pick < 6) req.start_x = 10'($urandom_range(1023, SCREEN_W));
        else if (pick < 9) req.row_y = 10'($urandom_range(1023, SCREEN_H));
        else if (pick < 12) req.span_width = '0;
        return req;
    endfunction

    task automatic run_random(int count, int send_pct, int recv_pct, bit with_hold);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 3) stall_tickets <= stall_tickets + 1;
            send_span(make_span_request());
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every op, clipping, rejects, wrap of the address
        set_frame_base(32'hffff_fff0);
        recv_idle_pct <= 30;
        send_span('{OP_SET,    10'd0,   10'd0,   10'd1});
        send_span('{OP_CLEAR,  10'd0,   10'd0,   10'd1023});
        send_span('{OP_INVERT, 10'd0,   10'd511, 10'd512});
        send_span('{OP_SET,    10'd511, 10'd511, 10'd1});
        send_span('{OP_CLEAR,  10'd511, 10'd3,   10'd1023});
        send_span('{OP_INVERT, 10'd3,   10'd7,   10'd2});
        send_span('{OP_SET,    10'd5,   10'd8,   10'd10});
        send_span('{OP_CLEAR,  10'd7,   10'd9,   10'd9});
        send_span('{OP_INVERT, 10'd8,   10'd10,  10'd8});
        send_span('{OP_INVERT, 10'd1,   10'd20,  10'd100});
        send_span('{OP_SET,    10'd504, 10'd1,   10'd8});
        send_span('{OP_SET,    10'd512, 10'd0,   10'd4});
        send_span('{OP_CLEAR,  10'd1023, 10'd0,  10'd4});
        send_span('{OP_SET,    10'd0,   10'd512, 10'd4});
        send_span('{OP_INVERT, 10'd0,   10'd1023, 10'd4});
        send_span('{OP_SET,    10'd10,  10'd10,  10'd0});
        send_span('{OP_NONE,   10'd10,  10'd10,  10'd30});
        send_span('{OP_NONE,   10'd1023, 10'd1023, 10'd1023});
        send_span('{OP_CLEAR,  10'd300, 10'd400, 10'd1});
        send_span('{OP_SET,    10'd6,   10'd2,   10'd2});
        wait_idle();

        set_frame_base(32'h0000_0000);
        run_random(160, 37, 81, 1'b1);
        wait_idle();

        set_frame_base($urandom);
        run_random(160, 81, 37, 1'b0);
        wait_idle();

        set_frame_base(32'hffff_ffff);
        run_random(150, 0, 0, 1'b0);
        wait_idle();

        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
src/msr_pkg.sv
src/msr_setup.sv
src/msr_emit.sv
src/mono_span_raster_op.sv
src/msr_checker.sv
verif/testbench.sv
